>>> rtl/core/pps_pkg.sv
// shared widths, constants and stage types for the path position sampler
package pps_pkg;

  localparam int ANG_W     = 37;  // q.32 angle, holds +-2*pi
  localparam int XY_W      = 36;  // q.32 cordic vector
  localparam int REM_W     = 64;  // dividend magnitude
  localparam int DVS_W     = 48;  // divisor, perimeter magnitude in q.32
  localparam int REM_STEPS = 49;  // quotient bits 48 down to 0
  localparam int RECT_W    = 56;  // rectangle coordinates in q.32

  localparam logic signed [ANG_W-1:0] TWO_PI_Q32  = 37'sd26986075409;
  localparam logic signed [ANG_W-1:0] PI_Q32      = 37'sd13493037705;
  localparam logic signed [ANG_W-1:0] HALF_PI_Q32 = 37'sd6746518852;
  localparam logic signed [XY_W-1:0]  CORDIC_GAIN_Q32 = 36'sd2608131496;

  localparam logic [31:0] ATAN_TBL [32] = '{
    32'd3373259426, 32'd1991351318, 32'd1052175346, 32'd534100635,
    32'd268086748,  32'd134174063,  32'd67103403,   32'd33553749,
    32'd16777131,   32'd8388597,    32'd4194303,    32'd2097152,
    32'd1048576,    32'd524288,     32'd262144,     32'd131072,
    32'd65536,      32'd32768,      32'd16384,      32'd8192,
    32'd4096,       32'd2048,       32'd1024,       32'd512,
    32'd256,        32'd128,        32'd64,         32'd32,
    32'd16,         32'd8,          32'd4,          32'd2
  };

  function automatic logic [31:0] atan_q32(input logic [4:0] idx);
    return ATAN_TBL[idx];
  endfunction

  typedef struct packed {
    logic             vld;
    logic             neg;
    logic             zero;
    logic [REM_W-1:0] rem;
    logic [DVS_W-1:0] dvs;
  } rem_stage_t;

  typedef struct packed {
    logic vld;
    logic flip;
  } cord_tag_t;

endpackage

>>> rtl/core/pps_rem.sv
// pipelined restoring remainder, one quotient bit per stage
module pps_rem (
  input  logic                clk,
  input  logic                rst,
  input  pps_pkg::rem_stage_t din,
  output pps_pkg::rem_stage_t dout
);
  import pps_pkg::*;

  rem_stage_t stg [REM_STEPS+1];

  assign stg[0] = din;

  for (genvar k = 0; k < REM_STEPS; k++) begin : g_step
    localparam int SH = REM_STEPS - 1 - k;
    logic [REM_W+DVS_W-1:0] cand;
    logic                   fits;
    rem_stage_t             nxt;

    assign cand = {{REM_W{1'b0}}, stg[k].dvs} << SH;
    assign fits = cand <= {{DVS_W{1'b0}}, stg[k].rem};

    always_comb begin
      nxt = stg[k];
      if (fits) begin
        nxt.rem = stg[k].rem - cand[REM_W-1:0];
      end
      if (rst) begin
        nxt.vld = 1'b0;
      end
    end

    always_ff @(posedge clk) begin
      stg[k+1] <= nxt;
    end
  end

  assign dout = stg[REM_STEPS];

endmodule

>>> rtl/core/pps_cordic.sv
// pipelined cordic rotator, one micro-rotation per stage
module pps_cordic #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic                                clk,
  input  logic                                rst,
  input  pps_pkg::cord_tag_t                  tag_in,
  input  logic signed [pps_pkg::ANG_W-1:0]    ang_in,
  output pps_pkg::cord_tag_t                  tag_out,
  output logic signed [pps_pkg::XY_W-1:0]     cos_out,
  output logic signed [pps_pkg::XY_W-1:0]     sin_out
);
  import pps_pkg::*;

  logic signed [XY_W-1:0]  x [CORDIC_STAGES+1];
  logic signed [XY_W-1:0]  y [CORDIC_STAGES+1];
  logic signed [ANG_W-1:0] z [CORDIC_STAGES+1];
  cord_tag_t               tg [CORDIC_STAGES+1];

  assign x[0]  = CORDIC_GAIN_Q32;
  assign y[0]  = '0;
  assign z[0]  = ang_in;
  assign tg[0] = tag_in;

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_stg
    logic signed [XY_W-1:0]  dx;
    logic signed [XY_W-1:0]  dy;
    logic signed [ANG_W-1:0] at;

    assign dx = y[i] >>> i;
    assign dy = x[i] >>> i;
    assign at = $signed({{(ANG_W-32){1'b0}}, atan_q32(5'(i))});

    always_ff @(posedge clk) begin
      if (!z[i][ANG_W-1]) begin
        x[i+1] <= x[i] - dx;
        y[i+1] <= y[i] + dy;
        z[i+1] <= z[i] - at;
      end else begin
        x[i+1] <= x[i] + dx;
        y[i+1] <= y[i] - dy;
        z[i+1] <= z[i] + at;
      end
      tg[i+1] <= '{vld: tg[i].vld && !rst, flip: tg[i].flip};
    end
  end

  // folded by pi: both components change sign
  assign tag_out = tg[CORDIC_STAGES];
  assign cos_out = tg[CORDIC_STAGES].flip ? -x[CORDIC_STAGES] : x[CORDIC_STAGES];
  assign sin_out = tg[CORDIC_STAGES].flip ? -y[CORDIC_STAGES] : y[CORDIC_STAGES];

endmodule

>>> rtl/core/path_position_sampler.sv
// top level: config registers, multiply, fold, rectangle walk and output stage
//
//   channel   handshake                      payload
//   command   start, busy (always low)       elapsed_time
//   result    done, one cycle                pos_x, pos_y, pos_z, bad_mode
//   config    psel, penable, pwrite, pready  paddr, pwdata, prdata
//
// one item per cycle; items pass through the 49-step remainder pipeline and
// the cordic rotator.
// rst clears all valid bits and loads the register reset values.
// the receiver cannot stall; every item in flight comes out in order.
module path_position_sampler #(
  parameter int CORDIC_STAGES = 24
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready,
  input  logic               start,
  output logic               busy,
  input  logic [31:0]        elapsed_time,
  output logic               done,
  output logic signed [31:0] pos_x,
  output logic signed [31:0] pos_y,
  output logic signed [31:0] pos_z,
  output logic               bad_mode
);
  import pps_pkg::*;

  typedef enum logic [2:0] {
    REG_MODE, REG_CX, REG_CY, REG_CZ, REG_SIZE_A, REG_SIZE_B, REG_SPEED, REG_PHASE
  } reg_idx_t;

  typedef enum logic [1:0] {
    MODE_STATIC, MODE_CIRC, MODE_RECT, MODE_BAD
  } mode_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    if (v > 64'sd2147483647) begin
      return 32'sh7fffffff;
    end else if (v < -64'sd2147483648) begin
      return 32'sh80000000;
    end
    return v[31:0];
  endfunction

  // configuration registers
  mode_t                path_mode;
  logic signed [31:0]   center_x;
  logic signed [31:0]   center_y;
  logic signed [31:0]   center_z;
  logic [30:0]          size_a;
  logic [30:0]          size_b;
  logic signed [31:0]   speed;
  logic signed [31:0]   phase_or_perimeter;
  reg_idx_t             reg_idx;

  assign pready  = 1'b1;
  assign busy    = 1'b0;
  assign reg_idx = reg_idx_t'(paddr[4:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      path_mode          <= MODE_STATIC;
      center_x           <= '0;
      center_y           <= '0;
      center_z           <= '0;
      size_a             <= '0;
      size_b             <= '0;
      speed              <= '0;
      phase_or_perimeter <= 32'sd65536;
    end else if (psel && penable && pwrite && pready) begin
      unique case (reg_idx)
        REG_MODE:   path_mode          <= mode_t'(pwdata[1:0]);
        REG_CX:     center_x           <= pwdata;
        REG_CY:     center_y           <= pwdata;
        REG_CZ:     center_z           <= pwdata;
        REG_SIZE_A: size_a             <= pwdata[30:0];
        REG_SIZE_B: size_b             <= pwdata[30:0];
        REG_SPEED:  speed              <= pwdata;
        REG_PHASE:  phase_or_perimeter <= pwdata;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_MODE:   prdata = {30'b0, path_mode};
      REG_CX:     prdata = center_x;
      REG_CY:     prdata = center_y;
      REG_CZ:     prdata = center_z;
      REG_SIZE_A: prdata = {1'b0, size_a};
      REG_SIZE_B: prdata = {1'b0, size_b};
      REG_SPEED:  prdata = speed;
      REG_PHASE:  prdata = phase_or_perimeter;
    endcase
  end

  // stage 1: distance or angle product speed * time, q.32
  logic signed [64:0] mul_full;
  logic               s1_vld;
  logic signed [63:0] s1_prod;

  assign mul_full = speed * $signed({1'b0, elapsed_time});

  always_ff @(posedge clk) begin
    s1_prod <= mul_full[63:0];
    s1_vld  <= rst ? 1'b0 : start && !busy;
  end

  // stage 2: dividend; circular adds the phase before reducing by 2*pi
  logic               s2_vld;
  logic signed [64:0] s2_div;

  always_ff @(posedge clk) begin
    if (path_mode == MODE_CIRC) begin
      s2_div <= {s1_prod[63], s1_prod}
              + {{17{phase_or_perimeter[31]}}, phase_or_perimeter, 16'b0};
    end else begin
      s2_div <= {s1_prod[63], s1_prod};
    end
    s2_vld <= rst ? 1'b0 : s1_vld;
  end

  // remainder on magnitudes, sign restored afterwards
  logic [64:0] div_mag;
  logic [31:0] per_mag;
  rem_stage_t  rem_in;
  rem_stage_t  rem_out;

  assign div_mag = s2_div[64] ? 65'(-s2_div) : 65'(s2_div);
  assign per_mag = phase_or_perimeter[31] ? 32'(-phase_or_perimeter)
                                          : 32'(phase_or_perimeter);

  always_comb begin
    rem_in.vld = s2_vld;
    rem_in.neg = s2_div[64];
    rem_in.rem = div_mag[REM_W-1:0];
    if (path_mode == MODE_CIRC) begin
      rem_in.dvs  = DVS_W'(TWO_PI_Q32);
      rem_in.zero = 1'b0;
    end else begin
      rem_in.dvs  = {per_mag, 16'b0};
      rem_in.zero = per_mag == '0;
    end
  end

  pps_rem u_rem (
    .clk  (clk),
    .rst  (rst),
    .din  (rem_in),
    .dout (rem_out)
  );

  // fold stage 1: angle into (-pi, pi], rectangle progress with sign
  logic signed [ANG_W-1:0]  rem_ang;
  logic signed [RECT_W-1:0] rem_rect;
  logic                     f1_vld;
  logic signed [ANG_W-1:0]  f1_ang;
  logic signed [RECT_W-1:0] f1_r;

  assign rem_ang  = $signed(rem_out.rem[ANG_W-1:0]);
  assign rem_rect = $signed(rem_out.rem[RECT_W-1:0]);

  always_ff @(posedge clk) begin
    if (rem_out.neg) begin
      f1_ang <= (rem_ang < PI_Q32) ? -rem_ang : TWO_PI_Q32 - rem_ang;
    end else begin
      f1_ang <= (rem_ang > PI_Q32) ? rem_ang - TWO_PI_Q32 : rem_ang;
    end
    if (rem_out.zero) begin
      f1_r <= '0;
    end else begin
      f1_r <= rem_out.neg ? -rem_rect : rem_rect;
    end
    f1_vld <= rst ? 1'b0 : rem_out.vld;
  end

  // fold stage 2: into [-pi/2, pi/2]
  cord_tag_t               f2_tag;
  logic signed [ANG_W-1:0] f2_ang;

  always_ff @(posedge clk) begin
    if (f1_ang > HALF_PI_Q32) begin
      f2_ang      <= f1_ang - PI_Q32;
      f2_tag.flip <= 1'b1;
    end else if (f1_ang < -HALF_PI_Q32) begin
      f2_ang      <= f1_ang + PI_Q32;
      f2_tag.flip <= 1'b1;
    end else begin
      f2_ang      <= f1_ang;
      f2_tag.flip <= 1'b0;
    end
    f2_tag.vld <= rst ? 1'b0 : f1_vld;
  end

  cord_tag_t              cd_tag;
  logic signed [XY_W-1:0] cd_cos;
  logic signed [XY_W-1:0] cd_sin;

  pps_cordic #(
    .CORDIC_STAGES (CORDIC_STAGES)
  ) u_cordic (
    .clk     (clk),
    .rst     (rst),
    .tag_in  (f2_tag),
    .ang_in  (f2_ang),
    .tag_out (cd_tag),
    .cos_out (cd_cos),
    .sin_out (cd_sin)
  );

  // rectangle progress waits alongside the rotator
  logic signed [RECT_W-1:0] rdl [CORDIC_STAGES+1];

  always_ff @(posedge clk) begin
    rdl[0] <= f1_r;
    for (int i = 0; i < CORDIC_STAGES; i++) begin
      rdl[i+1] <= rdl[i];
    end
  end

  // radius multiply and rectangle edge walk
  logic signed [XY_W-3:0]   c_q30;
  logic signed [XY_W-3:0]   s_q30;
  logic signed [RECT_W-1:0] w;
  logic signed [RECT_W-1:0] h;
  logic signed [RECT_W-1:0] cx;
  logic signed [RECT_W-1:0] cy;
  logic signed [RECT_W-1:0] left;
  logic signed [RECT_W-1:0] right;
  logic signed [RECT_W-1:0] bottom;
  logic signed [RECT_W-1:0] top;
  logic signed [RECT_W-1:0] r;
  logic signed [RECT_W-1:0] ex_next;
  logic signed [RECT_W-1:0] ey_next;

  assign c_q30  = cd_cos[XY_W-1:2];
  assign s_q30  = cd_sin[XY_W-1:2];
  assign w      = $signed({{(RECT_W-47){1'b0}}, size_a, 16'b0});
  assign h      = $signed({{(RECT_W-47){1'b0}}, size_b, 16'b0});
  assign cx     = $signed({{(RECT_W-48){center_x[31]}}, center_x, 16'b0});
  assign cy     = $signed({{(RECT_W-48){center_y[31]}}, center_y, 16'b0});
  assign left   = cx - (w >>> 1);
  assign right  = cx + (w >>> 1);
  assign bottom = cy - (h >>> 1);
  assign top    = cy + (h >>> 1);
  assign r      = rdl[CORDIC_STAGES];

  always_comb begin
    priority if (r <= w) begin
      ex_next = left + r;
      ey_next = bottom;
    end else if (r <= w + h) begin
      ex_next = right;
      ey_next = bottom + (r - w);
    end else if (r <= w + w + h) begin
      ex_next = right - (r - w - h);
      ey_next = top;
    end else begin
      ex_next = left;
      ey_next = top - (r - w - w - h);
    end
  end

  logic                   m_vld;
  logic signed [65:0]     mx;
  logic signed [65:0]     my;
  logic signed [RECT_W-1:0] ex;
  logic signed [RECT_W-1:0] ey;

  always_ff @(posedge clk) begin
    mx    <= $signed({1'b0, size_a}) * c_q30;
    my    <= $signed({1'b0, size_a}) * s_q30;
    ex    <= ex_next;
    ey    <= ey_next;
    m_vld <= rst ? 1'b0 : cd_tag.vld;
  end

  // output stage: round, add center, saturate, pick by mode
  logic signed [65:0] mx_rnd;
  logic signed [65:0] my_rnd;
  logic signed [63:0] cir_x;
  logic signed [63:0] cir_y;
  logic signed [RECT_W-1:0] ex_rnd;
  logic signed [RECT_W-1:0] ey_rnd;

  assign mx_rnd = (mx + 66'sd536870912) >>> 30;
  assign my_rnd = (my + 66'sd536870912) >>> 30;
  assign cir_x  = 64'($signed(mx_rnd[39:0])) + 64'(center_x);
  assign cir_y  = 64'($signed(my_rnd[39:0])) + 64'(center_y);
  assign ex_rnd = (ex + 56'sd32768) >>> 16;
  assign ey_rnd = (ey + 56'sd32768) >>> 16;

  always_ff @(posedge clk) begin
    unique case (path_mode)
      MODE_STATIC: begin
        pos_x    <= center_x;
        pos_y    <= center_y;
        pos_z    <= center_z;
        bad_mode <= 1'b0;
      end
      MODE_CIRC: begin
        pos_x    <= sat32(cir_x);
        pos_y    <= sat32(cir_y);
        pos_z    <= center_z;
        bad_mode <= 1'b0;
      end
      MODE_RECT: begin
        pos_x    <= sat32(64'(ex_rnd));
        pos_y    <= sat32(64'(ey_rnd));
        pos_z    <= center_z;
        bad_mode <= 1'b0;
      end
      MODE_BAD: begin
        pos_x    <= '0;
        pos_y    <= '0;
        pos_z    <= '0;
        bad_mode <= 1'b1;
      end
    endcase
    done <= rst ? 1'b0 : m_vld;
  end

endmodule
